// ----- rtl/rpa_pkg.sv -----
// Shared constants, codes and types of the reference-counted page allocator.
`timescale 1ns / 1ps

package rpa_pkg;

  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_SHIFT = 12;
  localparam int COUNT_BITS = 8;

  localparam int IDX_W   = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  // page number of a 33-bit address: room for the page just past 4 GiB
  localparam int PN_W    = 33 - PAGE_SHIFT;

  localparam logic [31:0] PAGE_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration register indexes
  localparam logic [1:0] CFG_REGION_BASE = 2'd0;
  localparam logic [1:0] CFG_FIRST_FREE  = 2'd1;
  localparam logic [1:0] CFG_LIMIT       = 2'd2;

  localparam logic [31:0] RST_REGION_BASE = 32'h8000_0000;
  localparam logic [31:0] RST_FIRST_FREE  = 32'h8002_0000;
  localparam logic [31:0] RST_LIMIT       = 32'h8800_0000;

  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_ALLOC   = 3'd1;
  localparam logic [2:0] ACT_CALLOC  = 3'd2;
  localparam logic [2:0] ACT_FREE    = 3'd3;
  localparam logic [2:0] ACT_CFREE   = 3'd4;
  localparam logic [2:0] ACT_ADD_REF = 3'd5;

  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_BAD   = 3'd1;
  localparam logic [2:0] STAT_EMPTY = 3'd2;
  localparam logic [2:0] STAT_OVER  = 3'd3;
  localparam logic [2:0] STAT_SAT   = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_POP_WAIT,
    S_CNT_WAIT,
    S_INIT
  } fsm_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } page_chk_t;

endpackage

// ----- rtl/rpa_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module rpa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/rpa_page_check.sv -----
// Page address check: alignment, bounds and page index within the reference table.
`timescale 1ns / 1ps

module rpa_page_check import rpa_pkg::*; (
  input  logic [31:0] page_addr,
  input  logic [31:0] region_base,
  input  logic [31:0] first_free_addr,
  input  logic [31:0] limit_addr,
  output page_chk_t   chk
);

  logic [31:0] base_al;
  logic [31:0] rel;

  always_comb begin
    base_al = region_base & ~PAGE_MASK;
    rel     = page_addr - base_al;
    chk.ok  = ((page_addr & PAGE_MASK) == 32'd0) &&
              (page_addr >= first_free_addr) &&
              (page_addr < limit_addr) &&
              (page_addr >= base_al) &&
              ((rel >> PAGE_SHIFT) < 32'(NUM_PAGES));
    chk.idx = rel[PAGE_SHIFT +: IDX_W];
  end

endmodule

// ----- rtl/refcounted_page_allocator_core.sv -----
// Top level of the reference-counted page allocator: control, registers and memories.
`timescale 1ns / 1ps

// Reference-counted page allocator.
// Command channel: an action and page_addr are taken at an edge where start is
// high and busy is low. Exactly one result follows, shown for one cycle with
// done high; the receiver takes it at the edge that ends that cycle and cannot
// stall it. free_pages on a done beat is the stack depth after the step.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
// is always high, writes are meant for when no command is in flight.
// Steps, one command at a time: every command is decoded (S_DECODE), then run
// (S_EXEC), where a bad address, an empty stack or an undefined action ends.
// Free, counted free and add_ref then read the count (S_CNT_WAIT); counted
// alloc reads the stack and writes the count (S_POP_WAIT); plain alloc reads
// the stack, then the count; init walks the pages (S_INIT).
// Each step is bounded by the single-port count and stack RAMs: one or two reads,
// then a write-back to each RAM that changes, per command; init walks one page a cycle.
// The next command may be taken in the done cycle itself.
// Reset: the synchronous rst restores the register reset values and starts a
// clearing pass over every entry of the count RAM with busy high; config writes
// are still taken. The free stack RAM is not cleared, only entries below the
// depth are ever read.

module refcounted_page_allocator_core import rpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [31:0] page_addr,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // result
  output logic        done,
  output logic [31:0] granted_addr,
  output logic [2:0]  status,
  output logic        released,
  output logic [7:0]  ref_after,
  output logic [15:0] free_pages
);

  // config registers
  logic [31:0] region_base;
  logic [31:0] first_free_addr;
  logic [31:0] limit_addr;

  // control state
  fsm_t               state, state_next;
  logic [DEPTH_W-1:0] stack_depth, stack_depth_next;
  logic [DEPTH_W-1:0] init_cursor, init_cursor_next;
  logic [IDX_W-1:0]   clr_addr, clr_addr_next;
  logic [PN_W-1:0]    init_pn, init_pn_next;
  logic               init_bad, init_bad_next;
  logic               done_next;

  // command payload
  logic [2:0]         act_q, act_q_next;
  logic [31:0]        pa_q, pa_q_next;
  page_chk_t          chk_q, chk_q_next;
  logic [IDX_W-1:0]   idx_q, idx_q_next;

  // result beat
  logic [31:0]           granted_q, granted_next;
  logic [2:0]            status_q, status_next;
  logic                  released_q, released_next;
  logic [COUNT_BITS-1:0] ref_q, ref_next;

  // memory ports
  logic                  stk_we;
  logic [IDX_W-1:0]      stk_addr;
  logic [IDX_W-1:0]      stk_wdata;
  logic [IDX_W-1:0]      stk_rdata;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_addr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;

  // address arithmetic
  page_chk_t             chk;
  logic [31:0]           base_al;
  logic [PN_W-1:0]       base_pn;
  logic [PN_W-1:0]       limit_pn;
  logic [32:0]           ff_sum;
  logic [PN_W-1:0]       init_rel;
  logic                  init_ok;
  logic                  stack_full;
  logic [COUNT_BITS-1:0] cnt_dec;

  rpa_page_check u_check (
    .page_addr       (pa_q),
    .region_base     (region_base),
    .first_free_addr (first_free_addr),
    .limit_addr      (limit_addr),
    .chk             (chk)
  );

  rpa_ram #(.DEPTH(NUM_PAGES), .WIDTH(IDX_W)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

  rpa_ram #(.DEPTH(NUM_PAGES), .WIDTH(COUNT_BITS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  assign busy         = (state != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign granted_addr = granted_q;
  assign status       = status_q;
  assign released     = released_q;
  assign ref_after    = 8'(ref_q);
  assign free_pages   = 16'(stack_depth);

  always_comb begin
    base_al    = region_base & ~PAGE_MASK;
    base_pn    = {1'b0, region_base[31:PAGE_SHIFT]};
    limit_pn   = {1'b0, limit_addr[31:PAGE_SHIFT]};
    ff_sum     = {1'b0, first_free_addr} + {1'b0, PAGE_MASK};
    // page walked by init: within managed range by construction, so only the
    // reference table bounds remain to be checked
    init_rel   = init_pn - base_pn;
    init_ok    = (init_pn >= base_pn) && (32'(init_rel) < 32'(NUM_PAGES));
    stack_full = (stack_depth >= DEPTH_W'(NUM_PAGES));
    cnt_dec    = (cnt_rdata != '0) ? (cnt_rdata - COUNT_BITS'(1)) : '0;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base     <= RST_REGION_BASE;
      first_free_addr <= RST_FIRST_FREE;
      limit_addr      <= RST_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REGION_BASE: region_base     <= cfg_data;
        CFG_FIRST_FREE:  first_free_addr <= cfg_data;
        CFG_LIMIT:       limit_addr      <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      stack_depth <= '0;
      init_cursor <= '0;
      clr_addr    <= '0;
      init_bad    <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      stack_depth <= stack_depth_next;
      init_cursor <= init_cursor_next;
      clr_addr    <= clr_addr_next;
      init_bad    <= init_bad_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    act_q      <= act_q_next;
    pa_q       <= pa_q_next;
    chk_q      <= chk_q_next;
    idx_q      <= idx_q_next;
    init_pn    <= init_pn_next;
    granted_q  <= granted_next;
    status_q   <= status_next;
    released_q <= released_next;
    ref_q      <= ref_next;
  end

  always_comb begin
    state_next       = state;
    stack_depth_next = stack_depth;
    init_cursor_next = init_cursor;
    clr_addr_next    = clr_addr;
    init_pn_next     = init_pn;
    init_bad_next    = init_bad;
    done_next        = 1'b0;
    act_q_next       = act_q;
    pa_q_next        = pa_q;
    chk_q_next       = chk_q;
    idx_q_next       = idx_q;
    granted_next     = granted_q;
    status_next      = status_q;
    released_next    = released_q;
    ref_next         = ref_q;

    stk_we    = 1'b0;
    stk_addr  = stack_depth[IDX_W-1:0];
    stk_wdata = idx_q;
    cnt_we    = 1'b0;
    cnt_addr  = idx_q;
    cnt_wdata = '0;

    unique case (state)
      S_CLEAR: begin
        cnt_we        = 1'b1;
        cnt_addr      = clr_addr;
        clr_addr_next = clr_addr + IDX_W'(1);
        if (clr_addr == IDX_W'(NUM_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          act_q_next    = action;
          pa_q_next     = page_addr;
          granted_next  = '0;
          status_next   = STAT_OK;
          released_next = 1'b0;
          ref_next      = '0;
          state_next    = S_DECODE;
        end
      end

      S_DECODE: begin
        chk_q_next   = chk;
        idx_q_next   = chk.idx;
        init_pn_next = ff_sum[32:PAGE_SHIFT];
        state_next   = S_EXEC;
      end

      S_EXEC: begin
        priority case (act_q)
          ACT_INIT: begin
            init_cursor_next = '0;
            init_bad_next    = 1'b0;
            state_next       = S_INIT;
          end
          ACT_ALLOC, ACT_CALLOC: begin
            if (stack_depth == '0) begin
              status_next = STAT_EMPTY;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              // pop: read the top entry
              stack_depth_next = stack_depth - DEPTH_W'(1);
              stk_addr         = stack_depth_next[IDX_W-1:0];
              state_next       = S_POP_WAIT;
            end
          end
          ACT_FREE, ACT_CFREE, ACT_ADD_REF: begin
            if (!chk_q.ok) begin
              status_next = STAT_BAD;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              cnt_addr   = idx_q;
              state_next = S_CNT_WAIT;
            end
          end
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      S_POP_WAIT: begin
        idx_q_next   = stk_rdata;
        granted_next = base_al + (32'(stk_rdata) << PAGE_SHIFT);
        cnt_addr     = stk_rdata;
        if (act_q == ACT_CALLOC) begin
          cnt_we     = 1'b1;
          cnt_wdata  = COUNT_BITS'(1);
          ref_next   = COUNT_BITS'(1);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_CNT_WAIT;
        end
      end

      S_CNT_WAIT: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        priority case (act_q)
          ACT_FREE: begin
            ref_next = cnt_rdata;
            if (stack_full) begin
              status_next = STAT_OVER;
            end else begin
              stk_we           = 1'b1;
              stack_depth_next = stack_depth + DEPTH_W'(1);
              released_next    = 1'b1;
            end
          end
          ACT_CFREE: begin
            ref_next  = cnt_dec;
            cnt_we    = (cnt_rdata != '0);
            cnt_wdata = cnt_dec;
            // a page whose count is or becomes zero returns to the stack
            if (cnt_dec == '0) begin
              if (stack_full) begin
                status_next = STAT_OVER;
              end else begin
                stk_we           = 1'b1;
                stack_depth_next = stack_depth + DEPTH_W'(1);
                released_next    = 1'b1;
              end
            end
          end
          ACT_ADD_REF: begin
            if (cnt_rdata == COUNT_MAX) begin
              status_next = STAT_SAT;
              ref_next    = cnt_rdata;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rdata + COUNT_BITS'(1);
              ref_next  = cnt_wdata;
            end
          end
          default: begin
            // plain alloc
            ref_next = cnt_rdata;
          end
        endcase
      end

      S_INIT: begin
        if (init_pn < limit_pn) begin
          init_pn_next = init_pn + PN_W'(1);
          if (!init_ok) begin
            init_bad_next = 1'b1;
          end else if (stack_full) begin
            // overflow ends the walk and outranks a bad page
            status_next   = STAT_OVER;
            released_next = (init_cursor != '0);
            done_next     = 1'b1;
            state_next    = S_IDLE;
          end else begin
            stk_we           = 1'b1;
            stk_wdata        = init_rel[IDX_W-1:0];
            stack_depth_next = stack_depth + DEPTH_W'(1);
            init_cursor_next = init_cursor + DEPTH_W'(1);
          end
        end else begin
          status_next   = init_bad ? STAT_BAD : STAT_OK;
          released_next = (init_cursor != '0);
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/rpa_checker.sv -----
// Port-level checks of the page allocator and their bind to the top level.
`timescale 1ns / 1ps

module rpa_checker import rpa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] granted_addr,
  input logic [2:0]  status,
  input logic        released,
  input logic [15:0] free_pages
);

  // a command taken always leaves the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after a command beat");

  // a result beat lasts one cycle and the block is free during it
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy ##1 !done)
    else $error("result beat longer than one cycle or shown while busy");

  // an empty stack never grants a page
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_EMPTY |-> granted_addr == 32'd0 && free_pages == 16'd0)
    else $error("empty result with a granted page or nonzero depth");

  // a released page is on the stack; init may still flag skipped pages
  a_release_depth: assert property (@(posedge clk) disable iff (rst)
    done && released |-> free_pages != 16'd0 && status != STAT_EMPTY)
    else $error("released page with empty stack");

endmodule

bind refcounted_page_allocator_core rpa_checker u_rpa_checker (.*);
